// ----- rtl/heightmap_bilinear_sampler_top_macros.svh -----
// Assertion macros for the heightmap bilinear sampler.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle, checked outside reset.
`define HBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication into the next cycle, checked outside reset.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/hbs_pkg.sv -----
// Package with defaults, field widths and codes of the heightmap bilinear sampler.
package hbs_pkg;

  localparam int unsigned MAX_CELLS_DEF   = 63;
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned HEIGHT_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned VIDX_W     = 12;
  localparam int unsigned HVAL_W     = 16;
  localparam int unsigned QPOS_W     = 16;
  localparam int unsigned HOUT_W     = 32;

  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RST = 6'd63;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = 1'b1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ----- rtl/heightmap_bilinear_sampler_top.sv -----
// Heightmap bilinear sampler: height store, corner read sequencer and interpolation pipeline.
//
// Usage:
//  - Command channel: drive func_i and the payload with start_i; a transaction
//    is taken at a rising edge with start_i high and busy_o low.
//  - A load (func_i = 0) writes one height entry; it produces no result.
//  - A query (func_i = 1) clamps (x,z) to the grid, reads the four corner
//    heights one per cycle from a single-port synchronous RAM and blends them.
//  - Result channel: valid_o pulses for one cycle with height_out_o after
//    the read, product, accumulator and output registers. The receiver
//    cannot stall; a result is dropped if nobody samples it.
//  - Throughput: one load per cycle while busy_o is low; queries are paced by
//    their four corner reads sharing the one RAM port. busy_o drops during the
//    last corner read, so the next transaction is taken without a gap.
//  - Loads and reads go through the RAM port strictly in transaction order,
//    so a query always sees every load taken before it.
//  - Configuration: cfg_we_i writes grid_width (index 0) or grid_depth
//    (index 1); write only while no query is in flight.
//  - Reset: asynchronous, active low. Grid sizes return to 63, the pipeline
//    empties. RAM contents are undefined until loaded; no clearing pass.
`include "heightmap_bilinear_sampler_top_macros.svh"

module heightmap_bilinear_sampler_top
  import hbs_pkg::*;
#(
  parameter int unsigned MAX_CELLS   = MAX_CELLS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // command channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     func_i,
  input  logic [VIDX_W-1:0]        vertex_index_i,
  input  logic signed [HVAL_W-1:0] height_value_i,
  input  logic signed [QPOS_W-1:0] query_x_i,
  input  logic signed [QPOS_W-1:0] query_z_i,
  // result channel
  output logic                     valid_o,
  output logic signed [HOUT_W-1:0] height_out_o
);

  // Geometry of the store.
  localparam int unsigned SIDE  = MAX_CELLS + 1;
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(SIDE);     // cell index width
  localparam int unsigned MW    = 2 * CW + 1;       // address product width
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned HB    = HEIGHT_BITS;
  localparam int unsigned WW    = 2 * F + 1;        // corner weight width
  localparam int unsigned PW    = HB + 2 * F + 2;   // product and accumulator width
  localparam int unsigned RW    = PW + 16;          // rescale headroom
  localparam int unsigned SHR   = (2 * F >= 16) ? (2 * F - 16) : 0;
  localparam int unsigned SHL   = (2 * F < 16) ? (16 - 2 * F) : 0;

  localparam logic [F:0] ONE_FIX = (F + 1)'(1) << F;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] grid_width_q, grid_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GRID_SIZE_RST;
      grid_depth_q <= GRID_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH: grid_width_q <= cfg_data_i;
        REG_GRID_DEPTH: grid_depth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate grid sizes to the store's capacity.
  logic [CW-1:0] w_sat, d_sat;
  logic [CW:0]   row_len;

  always_comb begin
    w_sat   = (32'(grid_width_q) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(grid_width_q);
    d_sat   = (32'(grid_depth_q) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(grid_depth_q);
    row_len = (CW + 1)'(w_sat) + (CW + 1)'(1);
  end

  // Clamp the query position and split it into cell index and fraction.
  logic signed [31:0] qx, qz, top_x, top_z, cx, cz;
  logic [CW-1:0]      ix_new, iz_new, ixn_new, izn_new;
  logic [F-1:0]       fx_new, fz_new;

  always_comb begin
    qx    = 32'(query_x_i);
    qz    = 32'(query_z_i);
    top_x = $signed(32'(w_sat) << F);
    top_z = $signed(32'(d_sat) << F);
    priority if (qx < 0)     cx = '0;
    else if (qx > top_x)     cx = top_x;
    else                     cx = qx;
    priority if (qz < 0)     cz = '0;
    else if (qz > top_z)     cz = top_z;
    else                     cz = qz;
    ix_new  = cx[F +: CW];
    iz_new  = cz[F +: CW];
    fx_new  = cx[F-1:0];
    fz_new  = cz[F-1:0];
    ixn_new = (ix_new == w_sat) ? w_sat : CW'(ix_new + CW'(1));
    izn_new = (iz_new == d_sat) ? d_sat : CW'(iz_new + CW'(1));
  end

  // Load address check and height width adaption.
  logic [31:0]        vi_ext;
  logic signed [31:0] hv_ext;
  logic               ld_ok_new;

  always_comb begin
    vi_ext    = 32'(vertex_index_i);
    hv_ext    = 32'(height_value_i);
    ld_ok_new = vi_ext < 32'(DEPTH);
  end

  // Transaction slot: the one item that owns the RAM port.
  logic          slot_vld_q, slot_query_q;
  logic [1:0]    phase_q;
  logic [AW-1:0] ld_addr_q;
  logic [HB-1:0] ld_data_q;
  logic          ld_ok_q;
  logic [CW-1:0] ix_q, iz_q, ixn_q, izn_q;
  logic [F-1:0]  fx_q, fz_q;
  logic          accept, rd_issue, rd_last, mem_we;

  assign busy_o   = slot_vld_q && slot_query_q && (phase_q != 2'd3);
  assign accept   = start_i && !busy_o;
  assign rd_issue = slot_vld_q && slot_query_q;
  assign rd_last  = rd_issue && (phase_q == 2'd3);
  assign mem_we   = slot_vld_q && !slot_query_q && ld_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q   <= 1'b0;
      slot_query_q <= 1'b0;
      phase_q      <= 2'd0;
    end else if (accept) begin
      slot_vld_q   <= 1'b1;
      slot_query_q <= (func_i == FUNC_QUERY);
      phase_q      <= 2'd0;
    end else if (slot_vld_q && (!slot_query_q || phase_q == 2'd3)) begin
      slot_vld_q   <= 1'b0;
    end else if (rd_issue) begin
      phase_q      <= phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_addr_q <= vi_ext[AW-1:0];
      ld_data_q <= hv_ext[HB-1:0];
      ld_ok_q   <= ld_ok_new;
      ix_q      <= ix_new;
      iz_q      <= iz_new;
      ixn_q     <= ixn_new;
      izn_q     <= izn_new;
      fx_q      <= fx_new;
      fz_q      <= fz_new;
    end
  end

  // Corner select: phase bit 0 picks the next x index, bit 1 the next z row.
  logic [CW-1:0] xsel, zsel;
  logic [F:0]    wx, wz;
  logic [MW-1:0] rd_addr_full;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] wgt_d;

  always_comb begin
    xsel         = phase_q[0] ? ixn_q : ix_q;
    zsel         = phase_q[1] ? izn_q : iz_q;
    wx           = phase_q[0] ? {1'b0, fx_q} : ONE_FIX - {1'b0, fx_q};
    wz           = phase_q[1] ? {1'b0, fz_q} : ONE_FIX - {1'b0, fz_q};
    rd_addr_full = MW'(zsel) * MW'(row_len) + MW'(xsel);
    mem_addr     = rd_issue ? rd_addr_full[AW-1:0] : ld_addr_q;
    wgt_d        = WW'(wx) * WW'(wz);
  end

  // Height store: single port, registered read.
  logic [HB-1:0] mem [DEPTH];
  logic [HB-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= ld_data_q;
    end
    rdata_q <= mem[mem_addr];
  end

  // Read stage tags follow the data out of the RAM.
  logic          rd_vld_q, rd_first_q, rd_last_q;
  logic [WW-1:0] wgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q <= (phase_q == 2'd0);
    rd_last_q  <= (phase_q == 2'd3);
    wgt_q      <= wgt_d;
  end

  // Weight each corner height.
  logic                 mul_vld_q, mul_first_q, mul_last_q;
  logic signed [PW-1:0] prod_d, prod_q;

  assign prod_d = $signed(rdata_q) * $signed({1'b0, wgt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_first_q <= rd_first_q;
    mul_last_q  <= rd_last_q;
    prod_q      <= prod_d;
  end

  // Accumulate the four weighted corners.
  logic                 acc_done_q;
  logic signed [PW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_done_q <= 1'b0;
    end else begin
      acc_done_q <= mul_vld_q && mul_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      acc_q <= (mul_first_q ? PW'(0) : acc_q) + prod_q;
    end
  end

  // Rescale to 16 fraction bits (floor) and saturate to 32 bits.
  logic signed [RW-1:0] acc_ext, scaled;
  logic [RW-32:0]       scaled_hi;
  logic [HOUT_W-1:0]    res_d;

  always_comb begin
    acc_ext   = RW'(acc_q);
    scaled    = (acc_ext <<< SHL) >>> SHR;
    scaled_hi = scaled[RW-1:31];
    if ((&scaled_hi) || !(|scaled_hi)) begin
      res_d = scaled[HOUT_W-1:0];
    end else if (scaled[RW-1]) begin
      res_d = {1'b1, {(HOUT_W - 1){1'b0}}};
    end else begin
      res_d = {1'b0, {(HOUT_W - 1){1'b1}}};
    end
  end

  logic                     valid_q;
  logic signed [HOUT_W-1:0] height_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= acc_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_done_q) begin
      height_out_q <= $signed(res_d);
    end
  end

  assign valid_o      = valid_q;
  assign height_out_o = height_out_q;

  // A taken query holds the RAM port in the following cycle.
  `HBS_ASSERT_NEXT(a_query_holds_port, clk_i, rst_ni, accept && func_i == FUNC_QUERY, busy_o && rd_issue && phase_q == 2'd0, "query did not start its corner reads")
  // The last corner read produces the result through the read, product, accumulator and output registers.
  `HBS_ASSERT_IMPL(a_last_read_result, clk_i, rst_ni, rd_last, ##4 valid_o, "result missing after last corner read")
  // Each query holds the RAM port for all its corner reads, so results never come back to back.
  `HBS_ASSERT_NEXT(a_result_single, clk_i, rst_ni, valid_o, !valid_o, "results back to back")
  // A load never shares the port with a corner read.
  `HBS_ASSERT_IMPL(a_port_exclusive, clk_i, rst_ni, mem_we, !rd_issue && !busy_o, "write collides with read")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the heightmap bilinear sampler: directed table, random phases.
module testbench;
  import hbs_pkg::*;

  // Derived sizes of the default build of the block.
  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam longint      ONE_FIX     = longint'(1) << FRAC;
  localparam int unsigned STORE_DEPTH = (MAX_CELLS_DEF + 1) * (MAX_CELLS_DEF + 1);

  // Results still in flight in the block need time to come out; allow margin.
  localparam int unsigned DRAIN_CYCLES    = 16;
  // Cycles in a row with no transaction on either side before giving up.
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  // One command transaction; known/height carry a hand-written expectation.
  typedef struct packed {
    logic                    func;
    logic [VIDX_W-1:0]       vidx;
    logic [HVAL_W-1:0]       hval;
    logic [QPOS_W-1:0]       qx;
    logic [QPOS_W-1:0]       qz;
    logic                    known;
    logic [HOUT_W-1:0]       height;
  } step_t;

  logic                     clk;
  logic                     rst_n        = 1'b0;
  logic                     cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx      = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0]    cfg_data     = '0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic                     func         = FUNC_LOAD;
  logic [VIDX_W-1:0]        vertex_index = '0;
  logic signed [HVAL_W-1:0] height_value = '0;
  logic signed [QPOS_W-1:0] query_x      = '0;
  logic signed [QPOS_W-1:0] query_z      = '0;
  logic                     valid;
  logic signed [HOUT_W-1:0] height_out;

  // Shadow of the block: height store, which entries hold data, grid sizes.
  logic signed [HVAL_W-1:0] height_mem  [STORE_DEPTH];
  bit                       written_map [STORE_DEPTH];
  logic [CFG_DATA_W-1:0]    grid_w = GRID_SIZE_RST;
  logic [CFG_DATA_W-1:0]    grid_d = GRID_SIZE_RST;

  // Heights still owed by the block, oldest first.
  logic signed [HOUT_W-1:0] pending_heights [$];
  int unsigned              mismatch_count = 0;
  int unsigned              stall_cycles   = 0;

  // Directed part under the reset grid of 63 by 63 cells. Corners are loaded
  // before any query reads them; rows with known = 1 carry a typed result.
  step_t directed_steps [20] = '{
    '{FUNC_LOAD,  12'd0,    16'h7FFF, 16'h1234, 16'h5678, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd1,    16'h8000, 16'hFFFF, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd64,   16'd100,  16'h0000, 16'hFFFF, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd65,   16'hFFFF, 16'h8000, 16'h7FFF, 1'b0, 32'h0},
    // below the grid on both axes: pinned to the origin, zero fractions
    '{FUNC_QUERY, 12'hFFF,  16'hFFFF, 16'h8000, 16'h8000, 1'b1, 32'h7FFF_0000},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h7FFF_0000},
    '{FUNC_QUERY, 12'h555,  16'hAAAA, 16'h0080, 16'h0000, 1'b0, 32'h0},
    '{FUNC_QUERY, 12'hAAA,  16'h5555, 16'h0080, 16'h0080, 1'b0, 32'h0},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h00FF, 16'h00FF, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4030, 16'h1111, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4031, 16'h8001, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4094, 16'h7FFE, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4095, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4032, 16'd7,    16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FUNC_LOAD,  12'd4033, 16'hFFF9, 16'h0000, 16'h0000, 1'b0, 32'h0},
    // beyond the far corner: next indices clamp onto the last vertex
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, 32'h8000_0000},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h3F00, 16'h3F00, 1'b1, 32'h8000_0000},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h3E80, 16'h3EC0, 1'b0, 32'h0},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h8000, 16'h7FFF, 1'b1, 32'h0007_0000},
    '{FUNC_QUERY, 12'h000,  16'h0000, 16'h0040, 16'h3F00, 1'b0, 32'h0}
  };

  heightmap_bilinear_sampler_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .start_i        (start),
    .busy_o         (busy),
    .func_i         (func),
    .vertex_index_i (vertex_index),
    .height_value_i (height_value),
    .query_x_i      (query_x),
    .query_z_i      (query_z),
    .valid_o        (valid),
    .height_out_o   (height_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp one coordinate to [0, cells] in fixed point.
  function automatic longint clamp_coord(input logic [QPOS_W-1:0] raw,
                                         input int unsigned cells);
    longint c;
    longint top;
    c   = longint'($signed(raw));
    top = longint'(cells) << FRAC;
    if (c < 0) c = 0;
    if (c > top) c = top;
    return c;
  endfunction

  // Find the four corner addresses and the fractions of a query position.
  function automatic void locate_cell(input logic [QPOS_W-1:0] qx,
                                      input logic [QPOS_W-1:0] qz,
                                      output logic [3:0][VIDX_W-1:0] addr,
                                      output longint fx, output longint fz);
    int unsigned w, d, ix, iz, ixn, izn, row;
    longint      cx, cz;
    w   = (grid_w > MAX_CELLS_DEF) ? MAX_CELLS_DEF : grid_w;
    d   = (grid_d > MAX_CELLS_DEF) ? MAX_CELLS_DEF : grid_d;
    cx  = clamp_coord(qx, w);
    cz  = clamp_coord(qz, d);
    ix  = int'(cx >> FRAC);
    iz  = int'(cz >> FRAC);
    fx  = cx & (ONE_FIX - 1);
    fz  = cz & (ONE_FIX - 1);
    ixn = (ix + 1 > w) ? w : ix + 1;
    izn = (iz + 1 > d) ? d : iz + 1;
    row = w + 1;
    addr[0] = VIDX_W'(iz * row + ix);
    addr[1] = VIDX_W'(iz * row + ixn);
    addr[2] = VIDX_W'(izn * row + ix);
    addr[3] = VIDX_W'(izn * row + ixn);
  endfunction

  // Blend the four corners, rescale to 16 fraction bits and saturate.
  function automatic logic signed [HOUT_W-1:0] predict_height(input logic [QPOS_W-1:0] qx,
                                                             input logic [QPOS_W-1:0] qz);
    logic [3:0][VIDX_W-1:0] addr;
    longint fx, fz, h0, h1, acc;
    locate_cell(qx, qz, addr, fx, fz);
    h0  = longint'(height_mem[addr[0]]) * (ONE_FIX - fx) + longint'(height_mem[addr[1]]) * fx;
    h1  = longint'(height_mem[addr[2]]) * (ONE_FIX - fx) + longint'(height_mem[addr[3]]) * fx;
    acc = h0 * (ONE_FIX - fz) + h1 * fz;
    if (2 * FRAC >= 16) acc = acc >>> (2 * FRAC - 16);
    else acc = acc <<< (16 - 2 * FRAC);
    if (acc > longint'(32'sh7FFF_FFFF)) acc = longint'(32'sh7FFF_FFFF);
    if (acc < -longint'(64'sh8000_0000)) acc = -longint'(64'sh8000_0000);
    return acc[HOUT_W-1:0];
  endfunction

  // Heights biased toward the extremes of the signed range and toward small values near zero.
  function automatic logic [HVAL_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return HVAL_W'(int'($urandom_range(0, 15)) - 8);
      default: return HVAL_W'($urandom);
    endcase
  endfunction

  // Coordinates: inside the grid, on vertices, below it, on and past its edge, or random.
  function automatic logic [QPOS_W-1:0] pick_coord(input int unsigned cells);
    int unsigned top;
    top = cells << FRAC;
    case ($urandom_range(0, 9))
      0, 1:    return QPOS_W'($urandom);
      2:       return QPOS_W'(-int'($urandom_range(1, 32768)));
      3:       return QPOS_W'(top);
      4:       return QPOS_W'($urandom_range(0, cells) << FRAC);
      5:       return QPOS_W'(top + $urandom_range(1, 255));
      6:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return QPOS_W'($urandom_range(0, top));
    endcase
  endfunction

  // Drive one transaction, hold it until taken, then update the shadow and
  // queue the expected height. Idle afterwards with random payload noise.
  task automatic issue_cmd(input step_t s, input int unsigned idle_pct);
    start        <= 1'b1;
    func         <= s.func;
    vertex_index <= s.vidx;
    height_value <= s.hval;
    query_x      <= s.qx;
    query_z      <= s.qz;
    do @(posedge clk); while (busy);
    if (s.func == FUNC_LOAD) begin
      height_mem[s.vidx]  = s.hval;
      written_map[s.vidx] = 1'b1;
    end else begin
      pending_heights.push_back(s.known ? s.height : predict_height(s.qx, s.qz));
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start        <= 1'b0;
      func         <= 1'($urandom);
      vertex_index <= VIDX_W'($urandom);
      height_value <= HVAL_W'($urandom);
      query_x      <= QPOS_W'($urandom);
      query_z      <= QPOS_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Drain the block, then write both grid sizes back to back.
  task automatic write_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] d);
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    // loads leave no result behind; give any in flight time to land
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    grid_w   = w;
    cfg_idx  <= REG_GRID_DEPTH;
    cfg_data <= d;
    @(posedge clk);
    grid_d   = d;
    cfg_we   <= 1'b0;
  endtask

  // Random traffic: noise loads anywhere, and queries whose unwritten
  // corners are loaded first so that every read hits written data.
  task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct);
    int unsigned            sent;
    step_t                  s;
    logic [3:0][VIDX_W-1:0] addr;
    longint                 fx, fz;
    sent = 0;
    while (sent < count) begin
      s.known  = 1'b0;
      s.height = '0;
      if ($urandom_range(0, 99) < 35) begin
        s.func = FUNC_LOAD;
        s.vidx = VIDX_W'($urandom_range(0, STORE_DEPTH - 1));
        s.hval = pick_height();
        s.qx   = QPOS_W'($urandom);
        s.qz   = QPOS_W'($urandom);
        issue_cmd(s, idle_pct);
        sent++;
      end else begin
        s.qx = pick_coord(grid_w);
        s.qz = pick_coord(grid_d);
        locate_cell(s.qx, s.qz, addr, fx, fz);
        for (int k = 0; k < 4; k++) begin
          if (!written_map[addr[k]]) begin
            s.func = FUNC_LOAD;
            s.vidx = addr[k];
            s.hval = pick_height();
            issue_cmd(s, idle_pct);
            sent++;
          end
        end
        s.func = FUNC_QUERY;
        s.vidx = VIDX_W'($urandom);
        s.hval = HVAL_W'($urandom);
        issue_cmd(s, idle_pct);
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed table, then phases with fresh grid sizes.
  // Sender idles 9 percent in the first phases, 80 in the middle, none last.
  initial begin : stimulus
    int unsigned           idle_pct;
    logic [CFG_DATA_W-1:0] w, d;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_steps[i]) issue_cmd(directed_steps[i], 9);
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin w = 6'd1;  d = 6'd1;  end
        1:       begin w = 6'd0;  d = 6'd0;  end
        2:       begin w = 6'd63; d = 6'd0;  end
        3:       begin w = 6'd0;  d = 6'd63; end
        4:       begin w = 6'd63; d = 6'd63; end
        default: begin
          w = CFG_DATA_W'($urandom_range(1, 62));
          d = CFG_DATA_W'($urandom_range(1, 62));
        end
      endcase
      idle_pct = (p < 3) ? 9 : (p < 6) ? 80 : 0;
      write_grid(w, d);
      run_random_phase(ITEMS_PER_PHASE, idle_pct);
    end
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Compare each result against the oldest expected height; the result is
  // only valid for one cycle, so sample it at the edge that ends that cycle.
  // Also count cycles without any transaction and stop on a hang.
  always @(posedge clk) begin : result_check
    logic signed [HOUT_W-1:0] want;
    if (rst_n && valid) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d (0x%08h)",
                 $time, height_out, height_out);
        mismatch_count++;
      end else begin
        want = pending_heights.pop_front();
        if (height_out !== want) begin
          $display("%0t: height_out mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                   $time, want, want, height_out, height_out);
          mismatch_count++;
        end
      end
    end
    if ((start && !busy) || valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hbs_pkg.sv
rtl/heightmap_bilinear_sampler_top.sv
verif/testbench.sv
